@@ sv/keyed_record_table_top_macros.svh @@
// assertion macros used by the keyed record table top module
`ifndef KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every clock edge out of reset
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/krt_pkg.sv @@
// types, codes and default sizes for the keyed record table
package krt_pkg;

   // default sizes
   localparam int KRT_DEPTH     = 32;
   localparam int KRT_KEY_BITS  = 64;
   localparam int KRT_DATA_BITS = 64;

   // operation codes
   localparam logic [2:0] KRT_MODE_ADD    = 3'd0;
   localparam logic [2:0] KRT_MODE_FIND   = 3'd1;
   localparam logic [2:0] KRT_MODE_MODIFY = 3'd2;
   localparam logic [2:0] KRT_MODE_DELETE = 3'd3;
   localparam logic [2:0] KRT_MODE_LIST   = 3'd4;

   // status codes
   localparam logic [1:0] KRT_ST_OK       = 2'd0;
   localparam logic [1:0] KRT_ST_FULL     = 2'd1;
   localparam logic [1:0] KRT_ST_DUP      = 2'd2;
   localparam logic [1:0] KRT_ST_NOTFOUND = 2'd3;

   // request payload
   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] record_key;
      logic [63:0] record_data;
   } req_type;

   // response payload
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] found_key;
      logic [63:0] found_data;
      logic [5:0]  entry_count;
      logic        last;
   } rsp_type;

endpackage

@@ sv/krt_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
module krt_ram #(
   parameter int WIDTH = krt_pkg::KRT_KEY_BITS + krt_pkg::KRT_DATA_BITS,
   parameter int DEPTH = krt_pkg::KRT_DEPTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/keyed_record_table_top.sv @@
// keyed record table: sequencer around one record ram, with response register
`include "keyed_record_table_top_macros.svh"

// Keyed record table of up to DEPTH records kept in insertion order in one
// synchronous ram holding key and payload side by side. Once a request is
// accepted, the sequencer walks the ram through its single read port, one
// entry per cycle: add, find and modify search the filled entries up to a
// hit, delete searches up to the hit and then shifts every later entry down.
// List streams one response per cycle while the response channel takes
// them. The table is empty at reset and needs no clearing pass; entries at
// or above the fill count are never read. The response sits in an output
// register, so the next request is taken while the last response of the
// previous one still waits.
module keyed_record_table_top #(
   parameter int DEPTH     = krt_pkg::KRT_DEPTH,
   parameter int KEY_BITS  = krt_pkg::KRT_KEY_BITS,
   parameter int DATA_BITS = krt_pkg::KRT_DATA_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  krt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output krt_pkg::rsp_type rsp_payload
);

   import krt_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = KEY_BITS + DATA_BITS;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_LIST  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        hit_idx_ff, hit_idx_in;
   logic                 hit_pend_ff, hit_pend_in;
   logic [2:0]           mode_ff, mode_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [EW-1:0]        mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic [EW-1:0]        mem_rdata;

   logic [KEY_BITS-1:0]  rd_key;
   logic [DATA_BITS-1:0] rd_dat;
   logic [CW-1:0]        hit_prev;
   logic [CW-1:0]        cnt_dec;
   logic                 rsp_free;
   logic                 hit_match;

   // pack one response
   function automatic rsp_type pack_rsp(input logic [1:0] st, input logic [63:0] k,
                                        input logic [63:0] d, input logic [CW-1:0] n,
                                        input logic lst);
      rsp_type r;
      r.status      = st;
      r.found_key   = k;
      r.found_data  = d;
      r.entry_count = 6'(n);
      r.last        = lst;
      return r;
   endfunction

   krt_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_key    = mem_rdata[EW-1:DATA_BITS];
   assign rd_dat    = mem_rdata[DATA_BITS-1:0];
   assign hit_prev  = CW'(hit_idx_ff - 1'b1);
   assign cnt_dec   = CW'(cnt_ff - 1'b1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign hit_match = hit_pend_ff && (rd_key == key_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_pend_in  = hit_pend_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = hit_idx_ff[AW-1:0];
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in     = req_payload.mode;
               key_in      = req_payload.record_key[KEY_BITS-1:0];
               data_in     = req_payload.record_data[DATA_BITS-1:0];
               idx_in      = '0;
               hit_idx_in  = '0;
               hit_pend_in = 1'b0;
               case (req_payload.mode)
                  KRT_MODE_ADD: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        res_in   = pack_rsp(KRT_ST_FULL, '0, '0, cnt_ff, 1'b1);
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  KRT_MODE_FIND, KRT_MODE_MODIFY, KRT_MODE_DELETE: begin
                     state_in = ST_SCAN;
                  end
                  KRT_MODE_LIST: begin
                     if (cnt_ff == '0) begin
                        res_in   = pack_rsp(KRT_ST_NOTFOUND, '0, '0, cnt_ff, 1'b1);
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     res_in   = pack_rsp(KRT_ST_NOTFOUND, '0, '0, cnt_ff, 1'b1);
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // search: one read issued and one compare per cycle
         ST_SCAN: begin
            hit_pend_in = 1'b0;
            if (hit_match) begin
               case (mode_ff)
                  KRT_MODE_ADD: begin
                     res_in   = pack_rsp(KRT_ST_DUP, '0, '0, cnt_ff, 1'b1);
                     state_in = ST_DONE;
                  end
                  KRT_MODE_FIND: begin
                     res_in   = pack_rsp(KRT_ST_OK, 64'(rd_key), 64'(rd_dat), cnt_ff, 1'b1);
                     state_in = ST_DONE;
                  end
                  KRT_MODE_MODIFY: begin
                     mem_we    = 1'b1;
                     mem_waddr = hit_idx_ff[AW-1:0];
                     mem_wdata = {rd_key, data_ff};
                     res_in    = pack_rsp(KRT_ST_OK, '0, '0, cnt_ff, 1'b1);
                     state_in  = ST_DONE;
                  end
                  KRT_MODE_DELETE: begin
                     idx_in   = CW'(hit_idx_ff + 1'b1);
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     res_in   = pack_rsp(KRT_ST_NOTFOUND, '0, '0, cnt_ff, 1'b1);
                     state_in = ST_DONE;
                  end
               endcase
            end else if (idx_ff < cnt_ff) begin
               mem_re      = 1'b1;
               hit_pend_in = 1'b1;
               hit_idx_in  = idx_ff;
               idx_in      = CW'(idx_ff + 1'b1);
            end else if (mode_ff == KRT_MODE_ADD) begin
               // append at the fill position
               mem_we    = 1'b1;
               mem_waddr = cnt_ff[AW-1:0];
               mem_wdata = {key_ff, data_ff};
               cnt_in    = CW'(cnt_ff + 1'b1);
               res_in    = pack_rsp(KRT_ST_OK, '0, '0, CW'(cnt_ff + 1'b1), 1'b1);
               state_in  = ST_DONE;
            end else begin
               res_in   = pack_rsp(KRT_ST_NOTFOUND, '0, '0, cnt_ff, 1'b1);
               state_in = ST_DONE;
            end
         end

         // shift later entries down: read entry i, write it to i-1 next cycle
         ST_SHIFT: begin
            if (hit_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = hit_prev[AW-1:0];
               mem_wdata = mem_rdata;
            end
            if (idx_ff < cnt_ff) begin
               mem_re      = 1'b1;
               hit_pend_in = 1'b1;
               hit_idx_in  = idx_ff;
               idx_in      = CW'(idx_ff + 1'b1);
            end else begin
               hit_pend_in = 1'b0;
               if (!hit_pend_ff) begin
                  cnt_in   = cnt_dec;
                  res_in   = pack_rsp(KRT_ST_OK, '0, '0, cnt_dec, 1'b1);
                  state_in = ST_DONE;
               end
            end
         end

         // stream every entry, next read overlapped with each response load but the last
         ST_LIST: begin
            if (!hit_pend_ff) begin
               mem_re      = 1'b1;
               hit_pend_in = 1'b1;
               hit_idx_in  = idx_ff;
               idx_in      = CW'(idx_ff + 1'b1);
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = pack_rsp(KRT_ST_OK, 64'(rd_key), 64'(rd_dat), cnt_ff,
                                 hit_idx_ff == cnt_dec);
               if (hit_idx_ff == cnt_dec) begin
                  hit_pend_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  mem_re     = 1'b1;
                  hit_idx_in = idx_ff;
                  idx_in     = CW'(idx_ff + 1'b1);
               end
            end
         end

         // hand the single response to the output register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hit_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_pend_ff  <= hit_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      hit_idx_ff <= hit_idx_in;
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      data_ff    <= data_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // checks
   `KRT_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(DEPTH),
      "fill count above table depth")
   `KRT_ASSERT_NOW(a_write_state, clock, reset, mem_we,
      (state_ff == ST_SCAN) || (state_ff == ST_SHIFT), "ram write outside scan or shift")
   `KRT_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_we && mem_re,
      mem_waddr != mem_raddr, "ram read and write hit the same entry")
   `KRT_ASSERT_NEXT(a_cnt_step, clock, reset, 1'b1,
      (cnt_ff == $past(cnt_ff)) || (cnt_ff == CW'($past(cnt_ff) + 1'b1)) ||
      (cnt_ff == CW'($past(cnt_ff) - 1'b1)), "fill count moved by more than one")

endmodule
